/* rtl/assert_macros.svh */
// Assertion macros shared by the vector angle unit RTL.
// Depends on a clk and an active-high rst being in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, muted while in reset.
`define VAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* rtl/vau_pkg.sv */
// Package for the vector angle unit: widths, constants, word types, arctangent table.
// Used by every module of the unit; depends on nothing.
`default_nettype none

package vau_pkg;

  localparam int COMPONENT_BITS  = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_BITS      = 16;

  localparam int PROD_BITS  = 2 * COMPONENT_BITS;
  localparam int DOT_BITS   = PROD_BITS + 2;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int MAG_BITS   = PROD_BITS + 1;
  localparam int SH_BITS    = $clog2(MAG_BITS) + 1;

  localparam int NORM_BITS = 30;
  localparam int NORM_MSB  = NORM_BITS - 1;
  localparam int SQ_BITS   = 2 * NORM_BITS + 2;
  localparam int ROOT_BITS = NORM_BITS + 1;

  localparam int Z_FRAC       = 30;
  localparam int ZW           = Z_FRAC + 3;
  localparam int QW           = Z_FRAC + 4;
  localparam int CORDIC_ITERS = 28;
  localparam int GUARD        = 6;
  localparam int CW           = ROOT_BITS + GUARD + 3;

  localparam longint TAB0       = 64'd843314857;
  localparam longint PI_Q       = 4 * TAB0;
  localparam int     RND_SHIFT  = Z_FRAC - ANGLE_FRAC_BITS;
  localparam longint RND_HALF   = longint'(1) << (RND_SHIFT - 1);
  localparam longint PI_ANGLE_L = (PI_Q + RND_HALF) >>> RND_SHIFT;
  localparam logic [ANGLE_BITS-1:0] PI_ANGLE = ANGLE_BITS'(PI_ANGLE_L);
  localparam longint Z_LIMIT    = longint'(1) << (Z_FRAC + 1);

  typedef struct packed {
    logic op;
    logic dir;
    logic signed [COMPONENT_BITS-1:0] ax;
    logic signed [COMPONENT_BITS-1:0] ay;
    logic signed [COMPONENT_BITS-1:0] az;
    logic signed [COMPONENT_BITS-1:0] bx;
    logic signed [COMPONENT_BITS-1:0] by;
    logic signed [COMPONENT_BITS-1:0] bz;
  } in_t;

  typedef struct packed {
    logic zero;
    logic neg_dot;
    logic neg_cross;
  } flags_t;

  typedef struct packed {
    flags_t                 f;
    logic [NORM_BITS-1:0]   dm;
    logic [SQ_BITS-1:0]     sumsq;
  } front_t;

  typedef struct packed {
    flags_t                 f;
    logic [NORM_BITS-1:0]   dm;
    logic [ROOT_BITS-1:0]   root;
  } root_t;

  typedef struct packed {
    flags_t                 f;
    logic signed [ZW-1:0]   z;
  } ang_t;

  // atan(2^-i) in Q30
  function automatic logic [Z_FRAC-1:0] atan_tab(input int i);
    logic [Z_FRAC-1:0] r;
    unique case (i)
      0:       r = Z_FRAC'(TAB0);
      1:       r = Z_FRAC'(64'd497837830);
      2:       r = Z_FRAC'(64'd263043836);
      3:       r = Z_FRAC'(64'd133525159);
      4:       r = Z_FRAC'(64'd67021687);
      5:       r = Z_FRAC'(64'd33543516);
      6:       r = Z_FRAC'(64'd16775851);
      7:       r = Z_FRAC'(64'd8388437);
      8:       r = Z_FRAC'(64'd4194283);
      9:       r = Z_FRAC'(64'd2097149);
      default: r = Z_FRAC'(longint'(1) << (Z_FRAC - i));
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/vector_angle_unit_core.sv */
// Vector angle unit top level: stream ports, front end, square root, CORDIC, result stage.
// Uses vau_pkg, vau_front, vau_isqrt, vau_cordic and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Returns the angle between two 16-bit integer vectors as radians times 8192,
// rounded, within one LSB. tuser[0] selects 2D signed (1) or 3D (0); tuser[1]
// keeps the full 0..pi range in 3D. A zero-length vector gives pi and sets
// m_tuser. Fully pipelined: one word per cycle while the sink is ready, through
// the 7-stage front end, the 31-stage square root, the 28-stage CORDIC and the
// output register. A stall holds each full stage; empty stages still fill.
module vector_angle_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [1:0]  s_tuser,   // opcode, directed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // angle
  output logic        m_tuser    // zero_length
);
  import vau_pkg::*;

  in_t    in_w;
  front_t fr_w;
  root_t  rt_w;
  ang_t   an_w;
  logic   fr_valid, fr_ready, rt_valid, rt_ready, an_valid, an_ready;

  logic [QW-1:0]            q0, q1, q2;
  logic [QW-1:0]            r;
  logic [ANGLE_BITS-1:0]    res;

  localparam int CB = COMPONENT_BITS;

  assign in_w.op  = s_tuser[0];
  assign in_w.dir = s_tuser[1];
  assign in_w.ax  = s_tdata[0*CB +: CB];
  assign in_w.ay  = s_tdata[1*CB +: CB];
  assign in_w.az  = s_tdata[2*CB +: CB];
  assign in_w.bx  = s_tdata[3*CB +: CB];
  assign in_w.by  = s_tdata[4*CB +: CB];
  assign in_w.bz  = s_tdata[5*CB +: CB];

  vau_front u_front (
    .clk(clk), .rst(rst),
    .in_data(in_w), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_data(fr_w), .out_valid(fr_valid), .out_ready(fr_ready)
  );

  vau_isqrt u_isqrt (
    .clk(clk), .rst(rst),
    .in_data(fr_w), .in_valid(fr_valid), .in_ready(fr_ready),
    .out_data(rt_w), .out_valid(rt_valid), .out_ready(rt_ready)
  );

  vau_cordic u_cordic (
    .clk(clk), .rst(rst),
    .in_data(rt_w), .in_valid(rt_valid), .in_ready(rt_ready),
    .out_data(an_w), .out_valid(an_valid), .out_ready(an_ready)
  );

  always_comb begin
    q0 = (an_w.z < 0) ? '0 : QW'(an_w.z);
    q1 = an_w.f.neg_dot ? QW'(PI_Q) - q0 : q0;
    q2 = (q1 > QW'(PI_Q)) ? QW'(PI_Q) : q1;
    r  = (q2 + QW'(RND_HALF)) >> RND_SHIFT;
    if (an_w.f.zero) begin
      res = PI_ANGLE;
    end else if (an_w.f.neg_cross) begin
      res = ANGLE_BITS'(-r);
    end else begin
      res = ANGLE_BITS'(r);
    end
  end

  assign an_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (an_ready) begin
      m_tvalid <= an_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (an_ready) begin
      m_tdata <= res;
      m_tuser <= an_w.f.zero;
    end
  end

  `VAU_ASSERT(a_zero_gives_pi, m_tvalid && m_tuser |-> m_tdata == PI_ANGLE, "zero-length word without pi")
  `VAU_ASSERT(a_angle_range, m_tvalid |-> (m_tdata <= PI_ANGLE) || (m_tdata >= ANGLE_BITS'(-PI_ANGLE)), "angle beyond pi")

endmodule

`default_nettype wire

/* rtl/vau_front.sv */
// Front end: products, dot and cross sums, magnitudes, normalisation, sum of squares.
// Seven register stages; uses vau_pkg.
`default_nettype none

module vau_front (
  input  logic            clk,
  input  logic            rst,
  input  vau_pkg::in_t    in_data,
  input  logic            in_valid,
  output logic            in_ready,
  output vau_pkg::front_t out_data,
  output logic            out_valid,
  input  logic            out_ready
);
  import vau_pkg::*;

  localparam int NST = 7;

  logic [NST-1:0] v;
  logic [NST-1:0] adv;
  logic [NST-1:0] v_in;

  logic op1, dir1;
  logic zero1;
  logic signed [PROD_BITS-1:0] pxx, pyy, pzz, pyz, pzy, pzx, pxz, pxy, pyx;
  logic signed [COMPONENT_BITS-1:0] az_m, bz_m;
  logic za, zb;

  flags_t f2, f3, f4, f5, f6, f7;
  logic signed [DOT_BITS-1:0]   dot2;
  logic signed [CROSS_BITS-1:0] c0_2, c1_2, c2_2;

  logic [MAG_BITS-1:0] dm3, m0_3, m1_3, m2_3;
  logic [MAG_BITS-1:0] dm4, m0_4, m1_4, m2_4;
  logic [MAG_BITS-1:0] orv;
  logic [SH_BITS-1:0]  msb;
  logic                right4;
  logic [SH_BITS-1:0]  amt4;

  logic [NORM_BITS-1:0] dm5, m0_5, m1_5, m2_5;
  logic [NORM_BITS-1:0] dm6, dm7;
  logic [2*NORM_BITS-1:0] s0_6, s1_6, s2_6;
  logic [SQ_BITS-1:0]   sum7;

  always_comb begin
    adv[NST-1] = !v[NST-1] || out_ready;
    for (int i = 0; i < NST - 1; i++) begin
      adv[i] = !v[i] || adv[i+1];
    end
    v_in = {v[NST-2:0], in_valid};
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (adv[i]) begin
          v[i] <= v_in[i];
        end
      end
    end
  end

  always_comb begin
    az_m = in_data.op ? '0 : in_data.az;
    bz_m = in_data.op ? '0 : in_data.bz;
    za   = (in_data.ax == '0) && (in_data.ay == '0) && (az_m == '0);
    zb   = (in_data.bx == '0) && (in_data.by == '0) && (bz_m == '0);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      op1   <= in_data.op;
      dir1  <= in_data.dir;
      zero1 <= za || zb;
      pxx   <= PROD_BITS'(in_data.ax * in_data.bx);
      pyy   <= PROD_BITS'(in_data.ay * in_data.by);
      pzz   <= PROD_BITS'(az_m * bz_m);
      pyz   <= PROD_BITS'(in_data.ay * bz_m);
      pzy   <= PROD_BITS'(az_m * in_data.by);
      pzx   <= PROD_BITS'(az_m * in_data.bx);
      pxz   <= PROD_BITS'(in_data.ax * bz_m);
      pxy   <= PROD_BITS'(in_data.ax * in_data.by);
      pyx   <= PROD_BITS'(in_data.ay * in_data.bx);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dot2 <= DOT_BITS'(pxx) + DOT_BITS'(pyy) + DOT_BITS'(pzz);
      c0_2 <= CROSS_BITS'(pyz) - CROSS_BITS'(pzy);
      c1_2 <= CROSS_BITS'(pzx) - CROSS_BITS'(pxz);
      c2_2 <= CROSS_BITS'(pxy) - CROSS_BITS'(pyx);
      f2.zero      <= zero1;
      f2.neg_dot   <= ((DOT_BITS'(pxx) + DOT_BITS'(pyy) + DOT_BITS'(pzz)) < 0)
                      && !(!op1 && !dir1);
      f2.neg_cross <= op1 && ((CROSS_BITS'(pxy) - CROSS_BITS'(pyx)) < 0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      f3   <= f2;
      dm3  <= MAG_BITS'(dot2 < 0 ? -dot2 : dot2);
      m0_3 <= MAG_BITS'(c0_2 < 0 ? -c0_2 : c0_2);
      m1_3 <= MAG_BITS'(c1_2 < 0 ? -c1_2 : c1_2);
      m2_3 <= MAG_BITS'(c2_2 < 0 ? -c2_2 : c2_2);
    end
  end

  always_comb begin
    orv = dm3 | m0_3 | m1_3 | m2_3;
    msb = '0;
    for (int i = 0; i < MAG_BITS; i++) begin
      if (orv[i]) begin
        msb = SH_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      f4     <= f3;
      dm4    <= dm3;
      m0_4   <= m0_3;
      m1_4   <= m1_3;
      m2_4   <= m2_3;
      right4 <= msb > SH_BITS'(NORM_MSB);
      amt4   <= (msb > SH_BITS'(NORM_MSB)) ? msb - SH_BITS'(NORM_MSB)
                                           : SH_BITS'(NORM_MSB) - msb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      f5   <= f4;
      dm5  <= NORM_BITS'(right4 ? dm4 >> amt4 : dm4 << amt4);
      m0_5 <= NORM_BITS'(right4 ? m0_4 >> amt4 : m0_4 << amt4);
      m1_5 <= NORM_BITS'(right4 ? m1_4 >> amt4 : m1_4 << amt4);
      m2_5 <= NORM_BITS'(right4 ? m2_4 >> amt4 : m2_4 << amt4);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      f6   <= f5;
      dm6  <= dm5;
      s0_6 <= m0_5 * m0_5;
      s1_6 <= m1_5 * m1_5;
      s2_6 <= m2_5 * m2_5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      f7   <= f6;
      dm7  <= dm6;
      sum7 <= SQ_BITS'(s0_6) + SQ_BITS'(s1_6) + SQ_BITS'(s2_6);
    end
  end

  assign out_valid      = v[NST-1];
  assign out_data.f     = f7;
  assign out_data.dm    = dm7;
  assign out_data.sumsq = sum7;

endmodule

`default_nettype wire

/* rtl/vau_isqrt.sv */
// Pipelined floor square root of the cross-norm square, one root bit per stage.
// Uses vau_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vau_isqrt (
  input  logic            clk,
  input  logic            rst,
  input  vau_pkg::front_t in_data,
  input  logic            in_valid,
  output logic            in_ready,
  output vau_pkg::root_t  out_data,
  output logic            out_valid,
  input  logic            out_ready
);
  import vau_pkg::*;

  localparam int NST = ROOT_BITS;
  localparam int RW  = SQ_BITS + 2;

  logic [NST-1:0] v;
  logic [NST-1:0] adv;
  logic [NST-1:0] v_in;

  logic [RW-1:0]        rem_q  [NST];
  logic [ROOT_BITS-1:0] root_q [NST];
  flags_t               f_q    [NST];
  logic [NORM_BITS-1:0] dm_q   [NST];

  always_comb begin
    adv[NST-1] = !v[NST-1] || out_ready;
    for (int i = 0; i < NST - 1; i++) begin
      adv[i] = !v[i] || adv[i+1];
    end
    v_in = {v[NST-2:0], in_valid};
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (adv[i]) begin
          v[i] <= v_in[i];
        end
      end
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_bit
    localparam int K = NST - 1 - i;
    logic [RW-1:0]        rem_in;
    logic [ROOT_BITS-1:0] root_in;
    flags_t               f_in;
    logic [NORM_BITS-1:0] dm_in;
    logic [RW-1:0]        trial;

    if (i == 0) begin : g_first
      assign rem_in  = RW'(in_data.sumsq);
      assign root_in = '0;
      assign f_in    = in_data.f;
      assign dm_in   = in_data.dm;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign f_in    = f_q[i-1];
      assign dm_in   = dm_q[i-1];
    end

    assign trial = (RW'(root_in) << (K + 1)) | (RW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        f_q[i]  <= f_in;
        dm_q[i] <= dm_in;
        if (rem_in >= trial) begin
          rem_q[i]  <= rem_in - trial;
          root_q[i] <= root_in | (ROOT_BITS'(1) << K);
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= root_in;
        end
      end
    end
  end

  assign out_valid     = v[NST-1];
  assign out_data.f    = f_q[NST-1];
  assign out_data.dm   = dm_q[NST-1];
  assign out_data.root = root_q[NST-1];

  `VAU_ASSERT(a_root_normalised, out_valid && !out_data.f.zero |-> out_data.dm[NORM_MSB] || ((out_data.root >> NORM_MSB) != '0), "neither dot nor root in normalised range")

endmodule

`default_nettype wire

/* rtl/vau_cordic.sv */
// Vectoring CORDIC: arctangent of root over dot magnitude, one iteration per stage, Q30 angle.
// Uses vau_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vau_cordic (
  input  logic           clk,
  input  logic           rst,
  input  vau_pkg::root_t in_data,
  input  logic           in_valid,
  output logic           in_ready,
  output vau_pkg::ang_t  out_data,
  output logic           out_valid,
  input  logic           out_ready
);
  import vau_pkg::*;

  localparam int NST = CORDIC_ITERS;

  logic [NST-1:0] v;
  logic [NST-1:0] adv;
  logic [NST-1:0] v_in;

  logic signed [CW-1:0] x_q [NST];
  logic signed [CW-1:0] y_q [NST];
  logic signed [ZW-1:0] z_q [NST];
  flags_t               f_q [NST];

  always_comb begin
    adv[NST-1] = !v[NST-1] || out_ready;
    for (int i = 0; i < NST - 1; i++) begin
      adv[i] = !v[i] || adv[i+1];
    end
    v_in = {v[NST-2:0], in_valid};
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (adv[i]) begin
          v[i] <= v_in[i];
        end
      end
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_tab(i));
    logic signed [CW-1:0] x_in, y_in;
    logic signed [ZW-1:0] z_in;
    flags_t               f_in;

    if (i == 0) begin : g_first
      assign x_in = CW'({in_data.dm, GUARD'(0)});
      assign y_in = CW'({in_data.root, GUARD'(0)});
      assign z_in = '0;
      assign f_in = in_data.f;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign f_in = f_q[i-1];
    end

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        f_q[i] <= f_in;
        if (y_in >= 0) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + ANG;
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - ANG;
        end
      end
    end
  end

  assign out_valid  = v[NST-1];
  assign out_data.f = f_q[NST-1];
  assign out_data.z = z_q[NST-1];

  `VAU_ASSERT(a_angle_bounded, out_valid |-> (out_data.z < ZW'(Z_LIMIT)) && (out_data.z > -ZW'(Z_LIMIT)), "CORDIC angle out of range")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for vector_angle_unit_core: directed and random vector pairs
// with random source gaps and sink stalls, each result checked against a behavioural angle.
// Depends on the vector_angle_unit_core RTL and vau_pkg.
`default_nettype none

module testbench;

  import vau_pkg::*;

  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  DRAIN_CYCLES   = 90;
  localparam real ANGLE_SCALE    = 8192.0;
  localparam real ANGLE_TOL      = 1.5;
  localparam logic OP_3D = 1'b0;
  localparam logic OP_2D = 1'b1;

  typedef struct {
    logic zero;
    real  angle;
  } angle_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  angle_exp_t angle_q[$];
  int  errors = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  zero_seen = 0;
  int  idle_cycles = 0;
  bit  src_burst = 1'b0;
  bit  snk_burst = 1'b0;
  int  snk_wait = 0;

  vector_angle_unit_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  function automatic angle_exp_t predict_angle(input logic op, input logic dir,
                                               input logic signed [15:0] ax, ay, az,
                                               input logic signed [15:0] bx, by, bz);
    angle_exp_t r;
    longint a0, a1, a2, b0, b1, b2, dot, c0, c1, c2;
    real xm, ym, ang;
    a0 = ax; a1 = ay; a2 = az;
    b0 = bx; b1 = by; b2 = bz;
    if (op == OP_2D) begin
      a2 = 0;
      b2 = 0;
    end
    if ((a0 == 0 && a1 == 0 && a2 == 0) || (b0 == 0 && b1 == 0 && b2 == 0)) begin
      r.zero  = 1'b1;
      r.angle = real'($signed(PI_ANGLE));
      return r;
    end
    dot = a0 * b0 + a1 * b1 + a2 * b2;
    c0  = a1 * b2 - a2 * b1;
    c1  = a2 * b0 - a0 * b2;
    c2  = a0 * b1 - a1 * b0;
    xm  = (dot < 0) ? -real'(dot) : real'(dot);
    ym  = $sqrt(real'(c0) * real'(c0) + real'(c1) * real'(c1) + real'(c2) * real'(c2));
    ang = $atan2(ym, xm);
    if (dot < 0 && !(op == OP_3D && dir == 1'b0))
      ang = 3.14159265358979323846 - ang;
    if (op == OP_2D && c2 < 0)
      ang = -ang;
    r.zero  = 1'b0;
    r.angle = ang * ANGLE_SCALE;
    return r;
  endfunction

  task automatic send_pair(input logic op, input logic dir,
                           input logic signed [15:0] ax, ay, az, bx, by, bz);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {bz, by, bx, az, ay, ax};
    s_tuser  = {dir, op};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    angle_q.insert(angle_q.size(), predict_angle(op, dir, ax, ay, az, bx, by, bz));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (angle_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp(input int range_sel);
    case (range_sel)
      0:       return 16'($urandom);
      1:       return 16'($signed($urandom_range(0, 16)) - 8);
      2:       return 16'($signed($urandom_range(0, 512)) - 256);
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic test_directed();
    send_pair(OP_3D, 1'b1, 0, 0, 0, 5, 6, 7);
    send_pair(OP_3D, 1'b0, 1, 2, 3, 0, 0, 0);
    send_pair(OP_2D, 1'b0, 0, 0, 100, 3, 4, 0);
    send_pair(OP_2D, 1'b1, 3, 4, 9, 0, 0, -9);
    send_pair(OP_3D, 1'b1, 1, 0, 0, 1, 0, 0);
    send_pair(OP_3D, 1'b1, 1, 0, 0, -1, 0, 0);
    send_pair(OP_3D, 1'b0, 1, 0, 0, -1, 0, 0);
    send_pair(OP_3D, 1'b1, 1, 0, 0, 0, 1, 0);
    send_pair(OP_3D, 1'b0, 2, 1, 0, -3, 1, 5);
    send_pair(OP_3D, 1'b1, 2, 1, 0, -3, 1, 5);
    send_pair(OP_2D, 1'b0, 1, 0, 7, 0, 1, -7);
    send_pair(OP_2D, 1'b1, 0, 1, 0, 1, 0, 0);
    send_pair(OP_2D, 1'b0, 5, 5, 0, -5, -5, 0);
    send_pair(OP_2D, 1'b0, 5, 5, 0, 5, 5, 0);
    send_pair(OP_2D, 1'b1, 1, 0, 0, -1, -1, 0);
    send_pair(OP_3D, 1'b1, -32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(OP_3D, 1'b1, -32768, -32768, -32768, 32767, 32767, 32767);
    send_pair(OP_3D, 1'b0, 32767, -32768, 32767, -32768, 32767, -32768);
    send_pair(OP_2D, 1'b0, 32767, -32768, 0, -32768, -32768, 0);
    send_pair(OP_2D, 1'b1, -32768, 32767, -1, 32767, -32768, -1);
    send_pair(OP_3D, 1'b1, 32767, 1, 0, 32767, 0, 0);
    send_pair(OP_2D, 1'b0, 32767, 0, 0, 32767, -1, 0);
    send_pair(OP_3D, 1'b1, -1, -1, -1, 1, 1, 1);
  endtask

  task automatic test_random_pairs(input int count);
    logic signed [15:0] ax, ay, az, bx, by, bz;
    int k, shape, rsel;
    logic op;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) src_burst = ~src_burst;
      op    = 1'($urandom_range(0, 1));
      shape = $urandom_range(0, 9);
      rsel  = $urandom_range(0, 3);
      ax = rand_comp(rsel); ay = rand_comp(rsel); az = rand_comp(rsel);
      bx = rand_comp(rsel); by = rand_comp(rsel); bz = rand_comp(rsel);
      case (shape)
        0: begin
          ax = 0; ay = 0;
          if ($urandom_range(0, 1)) az = 0;
        end
        1: begin
          k  = $signed($urandom_range(0, 6)) - 3;
          bx = 16'(k * 50); by = 16'(k * 50); bz = 16'(k * 50);
          ax = 50; ay = 50; az = 50;
        end
        2: begin
          bx = -ay; by = ax; bz = 0; az = 0;
        end
        3: begin
          bx = -ax; by = -ay; bz = -az;
        end
        default: ;
      endcase
      send_pair(op, 1'($urandom_range(0, 1)), ax, ay, az, bx, by, bz);
    end
    src_burst = 1'b0;
  endtask

  task automatic test_pressure();
    wait_drained();
    repeat (3) send_pair(OP_2D, 1'b1, 16'($urandom), 16'($urandom), 0,
                         16'($urandom), 16'($urandom), 0);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (snk_wait > 0) begin
      snk_wait <= snk_wait - 1;
      m_tready <= 1'b0;
    end else if (m_tready && m_tvalid) begin
      if ($urandom_range(0, 29) == 0) snk_burst <= ~snk_burst;
      if (!snk_burst && $urandom_range(0, 2) == 0) begin
        snk_wait <= $urandom_range(0, 18);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    angle_exp_t e;
    real diff;
    if (!rst && m_tvalid && m_tready) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected word angle=%0d zero=%0b", $time, $signed(m_tdata), m_tuser);
        errors++;
      end else begin
        e = angle_q.pop_front();
        diff = real'($signed(m_tdata)) - e.angle;
        if (diff < 0.0) diff = -diff;
        if (m_tuser !== e.zero) begin
          $display("%0t: zero_length expected %0b actual %0b", $time, e.zero, m_tuser);
          errors++;
        end
        if ($isunknown(m_tdata) || diff > ANGLE_TOL) begin
          $display("%0t: angle expected %f actual %0d", $time, e.angle, $signed(m_tdata));
          errors++;
        end
        if (e.zero) zero_seen++;
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[vector_angle_unit_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_pairs(400);
    test_pressure();
    test_random_pairs(425);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d vector pairs in 2D and 3D modes, %0d results checked, %0d zero-length.",
             words_sent, words_checked, zero_seen);
    if (errors == 0 && angle_q.size() == 0) begin
      $display("[vector_angle_unit_core] OK");
    end else begin
      $display("[vector_angle_unit_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
